>>> rtl/core/lsbs_pkg.sv
// Shared constants for the link status blink sequencer: widths, register map, reset values.
package lsbs_pkg;

  localparam int unsigned TimerW   = 16;
  localparam int unsigned ElapsedW = 8;
  localparam int unsigned ModeW    = 8;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 16;
  localparam int unsigned AddrW    = 4;
  localparam int unsigned ApbDataW = 32;

  typedef enum logic [1:0] {
    REG_LINK_HOLD = 2'd0,
    REG_BLINK_ON  = 2'd1,
    REG_BLINK_OFF = 2'd2,
    REG_MODE_GAP  = 2'd3
  } reg_index_t;

  localparam logic [TimerW-1:0] LinkHoldReset = 16'd1000;
  localparam logic [TimerW-1:0] BlinkOnReset  = 16'd100;
  localparam logic [TimerW-1:0] BlinkOffReset = 16'd100;
  localparam logic [TimerW-1:0] ModeGapReset  = 16'd100;

endpackage

>>> rtl/core/link_status_blink_sequencer.sv
// Top level of the link status blink sequencer: tick stream in, LED state stream out.
//
// Takes one tick word per clock cycle and returns one result word per tick. The whole
// update (mode and link change detection, one saturating timer count-down and the blink
// start) runs in the cycle the tick is accepted; the result appears in the output register
// on the next cycle and is held there until taken. s_axis_tready stays high while that
// register is empty or being drained in the same cycle, so a tick can be accepted every
// cycle. Write timer settings over the APB port while no tick is in flight; unchecked.
module link_status_blink_sequencer (
  input  logic                             clk,
  input  logic                             rst,

  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // elapsed_ms[7:0], mode_number[15:8], partner_present[16], zero[23:17]
  input  logic [lsbs_pkg::InDataW-1:0]     s_axis_tdata,

  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // status_led[0], link_up[1], blinks_pending[9:2], zero[15:10]
  output logic [lsbs_pkg::OutDataW-1:0]    m_axis_tdata,

  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lsbs_pkg::AddrW-1:0]       paddr,
  input  logic [lsbs_pkg::ApbDataW-1:0]    pwdata,
  output logic [lsbs_pkg::ApbDataW-1:0]    prdata,
  output logic                             pready
);
  import lsbs_pkg::*;

  logic [TimerW-1:0] link_hold_ms;
  logic [TimerW-1:0] blink_on_ms;
  logic [TimerW-1:0] blink_off_ms;
  logic [TimerW-1:0] mode_gap_ms;

  logic              link_seen;
  logic [ModeW-1:0]  blinks_left;
  logic [ModeW-1:0]  last_mode;
  logic              primed;
  logic [TimerW-1:0] lit_timer;
  logic [TimerW-1:0] dark_timer;
  logic              led_level;

  logic              link_seen_next;
  logic [ModeW-1:0]  blinks_left_next;
  logic [TimerW-1:0] lit_timer_next;
  logic [TimerW-1:0] dark_timer_next;
  logic              led_level_next;

  logic [ElapsedW-1:0] elapsed;
  logic [ModeW-1:0]    mode;
  logic                present;
  logic [ModeW-1:0]    ref_mode;
  logic                mode_chg;
  logic [ModeW-1:0]    blinks_mid;
  logic [TimerW-1:0]   lit_mid;
  logic [TimerW-1:0]   dark_mid;
  logic [TimerW-1:0]   elapsed_ext;
  logic [TimerW-1:0]   lit_dec;
  logic [TimerW-1:0]   dark_dec;

  logic              accept;
  logic              cfg_wr;
  reg_index_t        cfg_idx;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign elapsed = s_axis_tdata[ElapsedW-1:0];
  assign mode    = s_axis_tdata[ElapsedW +: ModeW];
  assign present = s_axis_tdata[ElapsedW+ModeW];

  assign elapsed_ext = {{(TimerW-ElapsedW){1'b0}}, elapsed};

  always_comb begin
    ref_mode   = primed ? last_mode : mode;
    mode_chg   = (mode != ref_mode);
    blinks_mid = mode_chg ? mode : blinks_left;
    if (mode_chg) begin
      dark_mid = ((blinks_left != '0) || led_level) ? mode_gap_ms : '0;
    end else begin
      dark_mid = dark_timer;
    end
    link_seen_next = present;
    lit_mid        = (present != link_seen) ? link_hold_ms : lit_timer;

    lit_dec  = (lit_mid > elapsed_ext) ? (lit_mid - elapsed_ext) : '0;
    dark_dec = (dark_mid > elapsed_ext) ? (dark_mid - elapsed_ext) : '0;

    lit_timer_next   = lit_mid;
    dark_timer_next  = dark_mid;
    blinks_left_next = blinks_mid;
    led_level_next   = led_level;
    if (lit_mid != '0) begin
      lit_timer_next = lit_dec;
      led_level_next = (lit_dec != '0);
    end else if (dark_mid != '0) begin
      dark_timer_next = dark_dec;
    end else if (blinks_mid != '0) begin
      lit_timer_next   = blink_on_ms;
      dark_timer_next  = blink_off_ms;
      blinks_left_next = blinks_mid - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_seen     <= 1'b0;
      blinks_left   <= '0;
      last_mode     <= '0;
      primed        <= 1'b0;
      lit_timer     <= '0;
      dark_timer    <= '0;
      led_level     <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        link_seen   <= link_seen_next;
        blinks_left <= blinks_left_next;
        last_mode   <= mode;
        primed      <= 1'b1;
        lit_timer   <= lit_timer_next;
        dark_timer  <= dark_timer_next;
        led_level   <= led_level_next;
      end
      if (s_axis_tready) begin
        m_axis_tvalid <= s_axis_tvalid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tdata <= {{(OutDataW-ModeW-2){1'b0}}, blinks_left_next, link_seen_next,
                       led_level_next};
    end
  end

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_index_t'(paddr[AddrW-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      link_hold_ms <= LinkHoldReset;
      blink_on_ms  <= BlinkOnReset;
      blink_off_ms <= BlinkOffReset;
      mode_gap_ms  <= ModeGapReset;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_LINK_HOLD: link_hold_ms <= pwdata[TimerW-1:0];
        REG_BLINK_ON:  blink_on_ms  <= pwdata[TimerW-1:0];
        REG_BLINK_OFF: blink_off_ms <= pwdata[TimerW-1:0];
        REG_MODE_GAP:  mode_gap_ms  <= pwdata[TimerW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_LINK_HOLD: prdata = {{(ApbDataW-TimerW){1'b0}}, link_hold_ms};
      REG_BLINK_ON:  prdata = {{(ApbDataW-TimerW){1'b0}}, blink_on_ms};
      REG_BLINK_OFF: prdata = {{(ApbDataW-TimerW){1'b0}}, blink_off_ms};
      REG_MODE_GAP:  prdata = {{(ApbDataW-TimerW){1'b0}}, mode_gap_ms};
      default:       prdata = '0;
    endcase
  end

endmodule
